### design/u8s_pkg.sv
// ----------------------------------------------------------------------------
// u8s_pkg
// Shared types and constants of the UTF-8 stream sanitizer.
// ----------------------------------------------------------------------------
package u8s_pkg;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_OVERLONG  = 2'd0;
    localparam logic [1:0] REG_SURROGATE = 2'd1;
    localparam logic [1:0] REG_RANGE     = 2'd2;
    localparam logic [1:0] REG_NONCHAR   = 2'd3;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // replacement character U+FFFD in UTF-8
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] CP_SUR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SUR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_NC_LO    = 21'h00FDD0;
    localparam logic [20:0] CP_NC_HI    = 21'h00FDEF;
    localparam logic [20:0] CP_MIN_2B   = 21'h000080;
    localparam logic [20:0] CP_MIN_3B   = 21'h000800;
    localparam logic [20:0] CP_MIN_4B   = 21'h010000;
    localparam logic [20:0] CP_MAX_1B   = 21'h00007F;
    localparam logic [20:0] CP_MAX_2B   = 21'h0007FF;
    localparam logic [20:0] CP_MAX_3B   = 21'h00FFFF;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    typedef struct packed {
        logic reject_overlong;
        logic reject_surrogate;
        logic reject_out_of_range;
        logic reject_nonchar;
    } t_cfg;

    // one input byte's worth of output: replacement count, then literal bytes
    typedef struct packed {
        logic [2:0]      rep_cnt;
        logic [2:0]      lit_len;
        logic [3:0][7:0] lit;
    } t_cmd;

endpackage

### design/u8s_if.sv
// ----------------------------------------------------------------------------
// u8s_if
// Valid/ready channels of the UTF-8 stream sanitizer.
// ----------------------------------------------------------------------------
interface u8s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8s_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_replacement;
    logic       run_last;

    modport source (output valid, output out_byte, output is_replacement, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input is_replacement, input run_last,
                    output ready);
endinterface

### design/u8s_front.sv
// ----------------------------------------------------------------------------
// u8s_front
// Decodes input bytes, tracks the pending sequence, pushes output commands.
// ----------------------------------------------------------------------------
module u8s_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    u8s_in_if.sink         i_in,
    input  u8s_pkg::t_cfg  i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output u8s_pkg::t_cmd  o_cmd
);
    import u8s_pkg::*;

    logic [2:0]  r_seq_len, n_seq_len;
    logic [1:0]  r_taken, n_taken;
    logic [20:0] r_cp, n_cp;

    logic        acc;
    logic        pending;
    logic        is_cont;
    logic [7:0]  b;
    logic        eot;

    logic        ld_ascii;
    logic        ld_bad;
    logic [2:0]  ld_len;
    logic [20:0] ld_bits;

    logic [20:0]     cp_next;
    logic [2:0]      taken_inc;
    logic            fin_bad;
    logic            enc_repl;
    logic [2:0]      enc_len;
    logic [3:0][7:0] enc_bytes;
    logic            sur, oor, ovl, nonch;

    logic            use_lead;
    logic [2:0]      rep;
    logic [2:0]      lit_len;
    logic [3:0][7:0] lit;

    assign b       = i_in.data_byte;
    assign eot     = i_in.end_of_text;
    assign i_in.ready = !i_q_full;
    assign acc     = i_in.valid && !i_q_full;
    assign pending = (r_seq_len != 3'd0) && (r_seq_len <= 3'd4) && (r_taken != 2'd0)
                     && ({1'b0, r_taken} < r_seq_len);
    assign is_cont = (b[7:6] == 2'b10);

    // lead byte classification
    always_comb begin
        ld_ascii = !b[7];
        ld_bad   = 1'b0;
        ld_len   = 3'd0;
        ld_bits  = '0;
        priority if (!b[7]) begin
            ld_len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            ld_len  = 3'd2;
            ld_bits = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            ld_len  = 3'd3;
            ld_bits = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            ld_len  = 3'd4;
            ld_bits = {18'd0, b[2:0]};
        end else begin
            ld_bad = 1'b1;
        end
    end

    assign cp_next   = {r_cp[14:0], b[5:0]};
    assign taken_inc = {1'b0, r_taken} + 3'd1;

    // checks on a completed code point
    always_comb begin
        ovl = ((r_seq_len == 3'd2) && (cp_next < CP_MIN_2B))
           || ((r_seq_len == 3'd3) && (cp_next < CP_MIN_3B))
           || ((r_seq_len == 3'd4) && (cp_next < CP_MIN_4B));
        sur = (cp_next >= CP_SUR_LO) && (cp_next <= CP_SUR_HI);
        oor = (cp_next > CP_MAX);
        nonch = ((cp_next >= CP_NC_LO) && (cp_next <= CP_NC_HI))
             || ((cp_next[15:1] == 15'h7FFF) && !oor);
        fin_bad = (i_cfg.reject_overlong && ovl) || (i_cfg.reject_surrogate && sur)
               || (i_cfg.reject_out_of_range && oor) || (i_cfg.reject_nonchar && nonch);
        enc_repl = oor || sur;
    end

    // shortest-form encoder
    always_comb begin
        enc_bytes = '0;
        priority if (cp_next <= CP_MAX_1B) begin
            enc_len      = 3'd1;
            enc_bytes[0] = {1'b0, cp_next[6:0]};
        end else if (cp_next <= CP_MAX_2B) begin
            enc_len      = 3'd2;
            enc_bytes[0] = {3'b110, cp_next[10:6]};
            enc_bytes[1] = {2'b10, cp_next[5:0]};
        end else if (cp_next <= CP_MAX_3B) begin
            enc_len      = 3'd3;
            enc_bytes[0] = {4'b1110, cp_next[15:12]};
            enc_bytes[1] = {2'b10, cp_next[11:6]};
            enc_bytes[2] = {2'b10, cp_next[5:0]};
        end else begin
            enc_len      = 3'd4;
            enc_bytes[0] = {5'b11110, cp_next[20:18]};
            enc_bytes[1] = {2'b10, cp_next[17:12]};
            enc_bytes[2] = {2'b10, cp_next[11:6]};
            enc_bytes[3] = {2'b10, cp_next[5:0]};
        end
    end

    // sequence tracking and command build
    always_comb begin
        n_seq_len = r_seq_len;
        n_taken   = r_taken;
        n_cp      = r_cp;
        rep       = 3'd0;
        lit_len   = 3'd0;
        lit       = '0;
        use_lead  = 1'b0;
        if (!pending) begin
            n_seq_len = 3'd0;
            n_taken   = 2'd0;
            n_cp      = '0;
            use_lead  = 1'b1;
        end else if (is_cont) begin
            if (taken_inc >= r_seq_len) begin
                if (fin_bad) begin
                    rep = r_seq_len;
                end else if (enc_repl) begin
                    rep = 3'd1;
                end else begin
                    lit_len = enc_len;
                    lit     = enc_bytes;
                end
                n_seq_len = 3'd0;
                n_taken   = 2'd0;
                n_cp      = '0;
            end else if (eot) begin
                // truncated at end of text
                rep       = taken_inc;
                n_seq_len = 3'd0;
                n_taken   = 2'd0;
                n_cp      = '0;
            end else begin
                n_cp    = cp_next;
                n_taken = taken_inc[1:0];
            end
        end else begin
            // broken sequence, then the byte is retried as a lead
            rep       = {1'b0, r_taken};
            n_seq_len = 3'd0;
            n_taken   = 2'd0;
            n_cp      = '0;
            use_lead  = 1'b1;
        end
        if (use_lead) begin
            if (ld_ascii) begin
                lit_len = 3'd1;
                lit[0]  = b;
            end else if (ld_bad || eot) begin
                rep = rep + 3'd1;
            end else begin
                n_seq_len = ld_len;
                n_taken   = 2'd1;
                n_cp      = ld_bits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= 3'd0;
            r_taken   <= 2'd0;
            r_cp      <= '0;
        end else if (acc) begin
            r_seq_len <= n_seq_len;
            r_taken   <= n_taken;
            r_cp      <= n_cp;
        end
    end

    assign o_push        = acc && ((rep != 3'd0) || (lit_len != 3'd0));
    assign o_cmd.rep_cnt = rep;
    assign o_cmd.lit_len = lit_len;
    assign o_cmd.lit     = lit;

endmodule

### design/u8s_cmdq.sv
// ----------------------------------------------------------------------------
// u8s_cmdq
// Small command FIFO between the decoder front and the byte emitter.
// ----------------------------------------------------------------------------
module u8s_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  u8s_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output u8s_pkg::t_cmd  o_cmd
);
    import u8s_pkg::*;

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr;
    logic [CMDQ_AW-1:0] r_rd;
    logic [CMDQ_CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CMDQ_CW'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + CMDQ_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + CMDQ_AW'(1);
            end
            r_cnt <= r_cnt + CMDQ_CW'(i_push) - CMDQ_CW'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command popped from an empty queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != CMDQ_CW'(CMDQ_DEPTH)) |-> ((r_wr - r_rd) == r_cnt[CMDQ_AW-1:0]))
        else $error("queue pointers disagree with fill count");

endmodule

### design/u8s_back.sv
// ----------------------------------------------------------------------------
// u8s_back
// Expands queued commands into output bytes, one byte per cycle while o_out is ready.
// ----------------------------------------------------------------------------
module u8s_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  u8s_pkg::t_cmd  i_cmd,
    output logic           o_pop,
    u8s_out_if.source      o_out
);
    import u8s_pkg::*;

    logic [2:0] r_rep_done;
    logic [1:0] r_phase;
    logic [1:0] r_lit_idx;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_repl;
    logic       r_out_last;

    logic       in_rep;
    logic       last;
    logic       load;
    logic [7:0] sel_byte;
    logic [7:0] repl_byte;

    assign in_rep = (r_rep_done < i_cmd.rep_cnt);
    assign load   = i_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        unique case (r_phase)
            2'd0:    repl_byte = REPL_B0;
            2'd1:    repl_byte = REPL_B1;
            default: repl_byte = REPL_B2;
        endcase
    end

    always_comb begin
        if (in_rep) begin
            sel_byte = repl_byte;
            last     = (r_phase == 2'd2) && ((r_rep_done + 3'd1) == i_cmd.rep_cnt)
                       && (i_cmd.lit_len == 3'd0);
        end else begin
            sel_byte = i_cmd.lit[r_lit_idx];
            last     = (({1'b0, r_lit_idx} + 3'd1) == i_cmd.lit_len);
        end
    end

    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_done  <= 3'd0;
            r_phase     <= 2'd0;
            r_lit_idx   <= 2'd0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            if (last) begin
                r_rep_done <= 3'd0;
                r_phase    <= 2'd0;
                r_lit_idx  <= 2'd0;
            end else if (in_rep) begin
                if (r_phase == 2'd2) begin
                    r_phase    <= 2'd0;
                    r_rep_done <= r_rep_done + 3'd1;
                end else begin
                    r_phase <= r_phase + 2'd1;
                end
            end else begin
                r_lit_idx <= r_lit_idx + 2'd1;
            end
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= sel_byte;
            r_out_repl <= in_rep;
            r_out_last <= last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.is_replacement = r_out_repl;
    assign o_out.run_last       = r_out_last;

    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid && r_out_last)
        else $error("command retired without a last-byte mark");

    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |-> (r_rep_done == 3'd0) && (r_phase == 2'd0) && (r_lit_idx == 2'd0))
        else $error("expansion counters left mid-command");

    a_rep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (r_rep_done <= i_cmd.rep_cnt) && (r_phase != 2'd3))
        else $error("replacement counter ran past its command");

endmodule

### design/utf8_stream_sanitizer.sv
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer
// Streaming UTF-8 validator that re-emits shortest-form bytes and U+FFFD.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-------------------------------------------
//  i_in     | in  | valid / ready  | data_byte[7:0], end_of_text
//  o_out    | out | valid / ready  | out_byte[7:0], is_replacement, run_last
//  apb      | in  | psel / penable | paddr[3:0], pwdata[31:0], prdata[31:0]
//
//  an input byte is decoded in the cycle it is accepted; up to four commands wait
//  in the queue, so input is taken every cycle while the queue has room
//  output runs at one byte per cycle while o_out is ready; an input causing k
//  result bytes (0..12) holds the emitter for all k, three for a bad byte
//  first result byte goes through the command queue and the output register
//  reset is synchronous and clears the sequence state, queue and config registers
//  an output stall fills the queue and then drops i_in.ready
// ----------------------------------------------------------------------------
module utf8_stream_sanitizer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    u8s_in_if.sink                     i_in,
    u8s_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [u8s_pkg::APB_AW-1:0] paddr,
    input  logic [u8s_pkg::APB_DW-1:0] pwdata,
    output logic [u8s_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import u8s_pkg::*;

    t_cfg r_cfg;
    logic rd_bit;

    logic q_full;
    logic push;
    t_cmd push_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_OVERLONG:  r_cfg.reject_overlong     <= pwdata[0];
                REG_SURROGATE: r_cfg.reject_surrogate    <= pwdata[0];
                REG_RANGE:     r_cfg.reject_out_of_range <= pwdata[0];
                REG_NONCHAR:   r_cfg.reject_nonchar      <= pwdata[0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_OVERLONG:  rd_bit = r_cfg.reject_overlong;
            REG_SURROGATE: rd_bit = r_cfg.reject_surrogate;
            REG_RANGE:     rd_bit = r_cfg.reject_out_of_range;
            REG_NONCHAR:   rd_bit = r_cfg.reject_nonchar;
            default:       rd_bit = 1'b0;
        endcase
    end

    assign prdata = {{(APB_DW-1){1'b0}}, rd_bit};

    u8s_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    u8s_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    u8s_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 stream sanitizer: directed and random byte
// streams, reject settings all off, all on and random, input gaps, output stalls.
// ----------------------------------------------------------------------------
module tb;
    import u8s_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_replacement;
        logic       run_last;
    } t_clean_byte;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    u8s_in_if  in_bus ();
    u8s_out_if out_bus ();

    utf8_stream_sanitizer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // decoder shadow state and settings
    logic        rej_overlong;
    logic        rej_surrogate;
    logic        rej_range;
    logic        rej_nonchar;
    logic [2:0]  pend_len;
    logic [2:0]  pend_taken;
    logic [20:0] pend_cp;

    t_clean_byte clean_bytes[$];
    t_clean_byte step_bytes[$];
    t_clean_byte want;

    int err_count;
    int bytes_sent;
    int in_burst;
    int out_burst;
    int out_hold;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // zero-wait stretches now and then, otherwise a random idle gap
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    function automatic void push_clean(logic [7:0] b, logic repl);
        if (step_bytes.size() < 12) step_bytes.push_back('{b, repl, 1'b0});
    endfunction

    function automatic void push_fffd();
        push_clean(REPL_B0, 1'b1);
        push_clean(REPL_B1, 1'b1);
        push_clean(REPL_B2, 1'b1);
    endfunction

    function automatic void drop_pending();
        pend_len   = 3'd0;
        pend_taken = 3'd0;
        pend_cp    = 21'd0;
    endfunction

    function automatic void reencode(logic [20:0] cp);
        if (cp > CP_MAX || (cp >= CP_SUR_LO && cp <= CP_SUR_HI)) begin
            push_fffd();
        end else if (cp <= CP_MAX_1B) begin
            push_clean(cp[7:0], 1'b0);
        end else if (cp <= CP_MAX_2B) begin
            push_clean({3'b110, cp[10:6]}, 1'b0);
            push_clean({2'b10, cp[5:0]}, 1'b0);
        end else if (cp <= CP_MAX_3B) begin
            push_clean({4'b1110, cp[15:12]}, 1'b0);
            push_clean({2'b10, cp[11:6]}, 1'b0);
            push_clean({2'b10, cp[5:0]}, 1'b0);
        end else begin
            push_clean({5'b11110, cp[20:18]}, 1'b0);
            push_clean({2'b10, cp[17:12]}, 1'b0);
            push_clean({2'b10, cp[11:6]}, 1'b0);
            push_clean({2'b10, cp[5:0]}, 1'b0);
        end
    endfunction

    function automatic void complete_sequence();
        logic [20:0] cp;
        logic        bad;
        cp  = pend_cp;
        bad = 1'b0;
        if (rej_overlong) begin
            if (pend_len == 3'd2 && cp < CP_MIN_2B) bad = 1'b1;
            if (pend_len == 3'd3 && cp < CP_MIN_3B) bad = 1'b1;
            if (pend_len == 3'd4 && cp < CP_MIN_4B) bad = 1'b1;
        end
        if (rej_surrogate && cp >= CP_SUR_LO && cp <= CP_SUR_HI) bad = 1'b1;
        if (rej_range && cp > CP_MAX) bad = 1'b1;
        if (rej_nonchar && ((cp >= CP_NC_LO && cp <= CP_NC_HI) ||
                            (cp[15:1] == 15'h7FFF && cp <= CP_MAX))) bad = 1'b1;
        if (bad) begin
            for (int i = 0; i < pend_len; i++) push_fffd();
        end else begin
            reencode(cp);
        end
        drop_pending();
    endfunction

    function automatic void start_sequence(logic [7:0] b, logic eot);
        if (b[7] == 1'b0) begin
            push_clean(b, 1'b0);
            return;
        end
        if (b[7:5] == 3'b110) begin
            pend_len = 3'd2;
            pend_cp  = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            pend_len = 3'd3;
            pend_cp  = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            pend_len = 3'd4;
            pend_cp  = {18'd0, b[2:0]};
        end else begin
            push_fffd();
            return;
        end
        if (eot) begin
            push_fffd();
            drop_pending();
            return;
        end
        pend_taken = 3'd1;
    endfunction

    // expected output bytes for one accepted input byte
    function automatic void sanitize_byte(logic [7:0] b, logic eot);
        step_bytes.delete();
        if (pend_len == 3'd0 || pend_len > 3'd4 || pend_taken == 3'd0 ||
            pend_taken >= pend_len) begin
            drop_pending();
            start_sequence(b, eot);
        end else if (b[7:6] == 2'b10) begin
            pend_cp    = {pend_cp[14:0], b[5:0]};
            pend_taken = pend_taken + 3'd1;
            if (pend_taken >= pend_len) begin
                complete_sequence();
            end else if (eot) begin
                for (int i = 0; i < pend_taken; i++) push_fffd();
                drop_pending();
            end
        end else begin
            // broken sequence: flush pending bytes, then restart on this byte
            for (int i = 0; i < pend_taken; i++) push_fffd();
            drop_pending();
            start_sequence(b, eot);
        end
        if (eot) drop_pending();
        if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].run_last = 1'b1;
        foreach (step_bytes[i]) clean_bytes.push_back(step_bytes[i]);
    endfunction

    // output check and stall draw
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (clean_bytes.size() == 0) begin
                $error("out_byte: expected none, got %02h", out_bus.out_byte);
                err_count++;
            end else begin
                want = clean_bytes.pop_front();
                if (out_bus.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte,
                           out_bus.out_byte);
                    err_count++;
                end
                if (out_bus.is_replacement !== want.is_replacement) begin
                    $error("is_replacement: expected %0b, got %0b", want.is_replacement,
                           out_bus.is_replacement);
                    err_count++;
                end
                if (out_bus.run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last,
                           out_bus.run_last);
                    err_count++;
                end
            end
            out_hold = draw_wait(out_burst);
        end
    end

    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            out_bus.ready <= 1'b0;
            out_hold--;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = draw_wait(in_burst);
        @(negedge i_clk);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.data_byte   <= b;
        in_bus.end_of_text <= eot;
        do @(posedge i_clk); while (!in_bus.ready);
        sanitize_byte(b, eot);
        bytes_sent++;
    endtask

    // sends the low n bytes of seq, most significant first; eot on the last one
    task automatic send_seq(input int n, input logic [31:0] seq, input logic eot);
        for (int i = n - 1; i >= 0; i--) send_byte(seq[i*8 +: 8], eot && i == 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DW - 1){1'b0}}, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // let the block run dry before touching the registers or ending
    task automatic drain();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (clean_bytes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_rejects(input logic [3:0] v);
        drain();
        write_reg(REG_OVERLONG, v[3]);
        write_reg(REG_SURROGATE, v[2]);
        write_reg(REG_RANGE, v[1]);
        write_reg(REG_NONCHAR, v[0]);
        {rej_overlong, rej_surrogate, rej_range, rej_nonchar} = v;
    endtask

    function automatic logic [31:0] utf8_encode(logic [20:0] cp, int len);
        case (len)
            1: return {24'd0, 1'b0, cp[6:0]};
            2: return {16'd0, 3'b110, cp[10:6], 2'b10, cp[5:0]};
            3: return {8'd0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
            default: return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                             2'b10, cp[5:0]};
        endcase
    endfunction

    function automatic int shortest_len(logic [20:0] cp);
        if (cp <= CP_MAX_1B) return 1;
        if (cp <= CP_MAX_2B) return 2;
        if (cp <= CP_MAX_3B) return 3;
        return 4;
    endfunction

    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        // stray continuation and bytes that can never lead
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF8, 1'b1);
    endtask

    task automatic test_multibyte_forms();
        send_seq(2, 32'h0000_C080, 1'b0);
        send_seq(3, 32'h00EF_BFBD, 1'b0);
        send_seq(4, 32'hF48F_BFBF, 1'b0);
        send_seq(4, 32'hF580_8080, 1'b0);
        send_seq(3, 32'h00ED_A080, 1'b1);
    endtask

    task automatic test_broken_sequences();
        send_seq(2, 32'h0000_C341, 1'b0);
        send_seq(2, 32'h0000_E282, 1'b1);
        send_seq(1, 32'h0000_00C3, 1'b1);
    endtask

    task automatic test_reject_settings();
        send_seq(2, 32'h0000_C080, 1'b0);
        send_seq(4, 32'hF080_8080, 1'b0);
        send_seq(3, 32'h00ED_A080, 1'b0);
        send_seq(4, 32'hF7BF_BFBF, 1'b0);
        send_seq(3, 32'h00EF_BFBF, 1'b1);
    endtask

    task automatic test_random_text(input int n_bytes);
        int          stop_at;
        int          kind;
        int          len;
        int          cut;
        int          plane;
        logic [20:0] cp;
        logic [31:0] enc;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind >= 8) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                case ($urandom_range(0, 7))
                    0: cp = 21'($urandom_range(0, 'h7F));
                    1: cp = 21'($urandom_range('h80, 'h7FF));
                    2: cp = 21'($urandom_range('h800, 'hFFFF));
                    3: cp = 21'($urandom_range('h10000, 'h10FFFF));
                    4: cp = 21'($urandom_range('hD800, 'hDFFF));
                    5: begin
                        plane = $urandom_range(0, 16);
                        if ($urandom_range(0, 1))
                            cp = 21'(CP_NC_LO + $urandom_range(0, 31));
                        else
                            cp = 21'((plane << 16) | 'hFFFE | $urandom_range(0, 1));
                    end
                    6: cp = 21'($urandom_range('h110000, 'h1FFFFF));
                    default: cp = 21'h00FFFD;
                endcase
                len = shortest_len(cp);
                if ($urandom_range(0, 3) == 0) len = $urandom_range(len, 4);
                enc = utf8_encode(cp, len);
                if (kind >= 6 && len > 1) begin
                    // truncated sequence, cut short by the next item or end of text
                    cut = $urandom_range(1, len - 1);
                    send_seq(cut, enc >> (8 * (len - cut)), $urandom_range(0, 1) == 1);
                end else begin
                    send_seq(len, enc, $urandom_range(0, 11) == 0);
                end
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_bus.valid       = 1'b0;
        in_bus.data_byte   = 8'd0;
        in_bus.end_of_text = 1'b0;
        out_bus.ready      = 1'b0;
        err_count          = 0;
        bytes_sent         = 0;
        in_burst           = 0;
        out_burst          = 0;
        out_hold           = 0;
        {rej_overlong, rej_surrogate, rej_range, rej_nonchar} = 4'b0000;
        drop_pending();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_plain_bytes();
        test_multibyte_forms();
        test_broken_sequences();
        set_rejects(4'b1111);
        test_reject_settings();
        set_rejects(4'b0000);
        test_random_text(15);
        set_rejects(4'b1111);
        test_random_text(15);
        for (int p = 0; p < 3; p++) begin
            set_rejects(4'($urandom_range(0, 15)));
            test_random_text(10);
        end
        drain();

        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### sim.f
design/u8s_pkg.sv
design/u8s_if.sv
design/u8s_front.sv
design/u8s_cmdq.sv
design/u8s_back.sv
design/utf8_stream_sanitizer.sv
tb/tb.sv
